// File: rtl/core/fpa_pkg.sv
package fpa_pkg;

  localparam logic [3:0] MODE_ADD      = 4'd0;
  localparam logic [3:0] MODE_SUB      = 4'd1;
  localparam logic [3:0] MODE_MUL      = 4'd2;
  localparam logic [3:0] MODE_DIV      = 4'd3;
  localparam logic [3:0] MODE_GT       = 4'd4;
  localparam logic [3:0] MODE_LT       = 4'd5;
  localparam logic [3:0] MODE_GE       = 4'd6;
  localparam logic [3:0] MODE_LE       = 4'd7;
  localparam logic [3:0] MODE_EQ       = 4'd8;
  localparam logic [3:0] MODE_NE       = 4'd9;
  localparam logic [3:0] MODE_MIN      = 4'd10;
  localparam logic [3:0] MODE_MAX      = 4'd11;
  localparam logic [3:0] MODE_INC      = 4'd12;
  localparam logic [3:0] MODE_DEC      = 4'd13;
  localparam logic [3:0] MODE_TO_INT   = 4'd14;
  localparam logic [3:0] MODE_FROM_INT = 4'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic signed [31:0] FX_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } fpa_out_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_MUL,
    CLS_DIV,
    CLS_DIV0
  } fpa_cls_t;

  typedef struct packed {
    fpa_cls_t cls;
    fpa_in_t  item;
  } fpa_entry_t;

endpackage

// File: rtl/core/fpa_front.sv
module fpa_front
  import fpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  fpa_in_t    in_data,
  output logic       q_push,
  output fpa_entry_t q_data,
  input  logic       q_full
);

  logic       valid_r;
  fpa_entry_t entry_r;
  fpa_entry_t entry_nxt;

  always_comb begin
    entry_nxt.item = in_data;
    if (in_data.mode == MODE_MUL) begin
      entry_nxt.cls = CLS_MUL;
    end else if (in_data.mode == MODE_DIV) begin
      entry_nxt.cls = (in_data.operand_b == '0) ? CLS_DIV0 : CLS_DIV;
    end else begin
      entry_nxt.cls = CLS_SIMPLE;
    end
  end

  assign in_stall = valid_r && q_full;
  assign q_push   = valid_r && !q_full;
  assign q_data   = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// File: rtl/core/fpa_queue.sv
module fpa_queue
  import fpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fpa_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output fpa_entry_t head
);

  fpa_entry_t           mem [QDEPTH];
  logic [QAW-1:0]       wr_r;
  logic [QAW-1:0]       rd_r;
  logic [QCW-1:0]       cnt_r;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/fpa_back.sv
module fpa_back
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  fpa_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output fpa_out_t   out_data
);

  localparam int NW = 34 + FRACTION_BITS;
  localparam logic [63:0] HALF = 64'((64'd1 << FRACTION_BITS) >> 1);

  typedef struct packed {
    fpa_cls_t           cls;
    fpa_out_t           res;
    logic signed [63:0] prod;
    logic [NW-1:0]      n;
    logic [32:0]        d;
    logic               neg;
  } s1_t;

  typedef struct packed {
    fpa_cls_t      cls;
    fpa_out_t      res;
    logic [NW-1:0] n;
    logic [32:0]   d;
    logic [33:0]   rem;
    logic [32:0]   q;
    logic          big;
    logic          neg;
  } pst_t;

  function automatic fpa_out_t sat33(logic signed [32:0] v);
    fpa_out_t r;
    r = '0;
    if (v[32] != v[31]) begin
      r.result_value = v[32] ? FX_MIN : FX_MAX;
      r.status       = ST_OVF;
    end else begin
      r.result_value = v[31:0];
    end
    return r;
  endfunction

  function automatic pst_t div_step(pst_t x);
    pst_t        y;
    logic [33:0] t;
    y = x;
    t = {x.rem[32:0], x.n[NW-1]};
    y.n   = x.n << 1;
    y.big = x.big | x.q[32];
    if (t >= {1'b0, x.d}) begin
      y.rem = t - {1'b0, x.d};
      y.q   = {x.q[31:0], 1'b1};
    end else begin
      y.rem = t;
      y.q   = {x.q[31:0], 1'b0};
    end
    return y;
  endfunction

  logic adv;
  logic s1_valid_r;
  s1_t  s1_r;
  s1_t  s1_nxt;
  pst_t p_in;
  logic p_valid_r [NW];
  pst_t p_r       [NW];
  pst_t p_nxt     [NW];
  logic     out_valid_r;
  fpa_out_t out_r;
  fpa_out_t out_nxt;

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [31:0]        ma;
  logic [31:0]        mb;

  assign a     = q_head.item.operand_a;
  assign b     = q_head.item.operand_b;
  assign ma    = a[31] ? 32'(-a) : 32'(a);
  assign mb    = b[31] ? 32'(-b) : 32'(b);
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    logic signed [63:0] fi;
    s1_nxt      = '0;
    s1_nxt.cls  = q_head.cls;
    s1_nxt.prod = a * b;
    s1_nxt.n    = (NW'(ma) << (FRACTION_BITS + 1)) + NW'(mb);
    s1_nxt.d    = {mb, 1'b0};
    s1_nxt.neg  = a[31] ^ b[31];
    fi          = 64'(a) <<< FRACTION_BITS;
    case (q_head.item.mode)
      MODE_ADD: s1_nxt.res = sat33(33'(a) + 33'(b));
      MODE_SUB: s1_nxt.res = sat33(33'(a) - 33'(b));
      MODE_MUL: s1_nxt.res = '0;
      MODE_DIV: begin
        if (q_head.cls == CLS_DIV0) begin
          s1_nxt.res.status       = ST_DIV0;
          s1_nxt.res.result_value = (a > 0) ? FX_MAX : ((a < 0) ? FX_MIN : '0);
        end
      end
      MODE_GT:  s1_nxt.res.compare_true = (a > b);
      MODE_LT:  s1_nxt.res.compare_true = (a < b);
      MODE_GE:  s1_nxt.res.compare_true = (a >= b);
      MODE_LE:  s1_nxt.res.compare_true = (a <= b);
      MODE_EQ:  s1_nxt.res.compare_true = (a == b);
      MODE_NE:  s1_nxt.res.compare_true = (a != b);
      MODE_MIN: s1_nxt.res.result_value = (a > b) ? b : a;
      MODE_MAX: s1_nxt.res.result_value = (a < b) ? b : a;
      MODE_INC: s1_nxt.res = sat33(33'(a) + 33'sd1);
      MODE_DEC: s1_nxt.res = sat33(33'(a) - 33'sd1);
      MODE_TO_INT: s1_nxt.res.result_value = a >>> FRACTION_BITS;
      default: begin
        if (fi > 64'(FX_MAX)) begin
          s1_nxt.res.result_value = FX_MAX;
          s1_nxt.res.status       = ST_OVF;
        end else if (fi < 64'(FX_MIN)) begin
          s1_nxt.res.result_value = FX_MIN;
          s1_nxt.res.status       = ST_OVF;
        end else begin
          s1_nxt.res.result_value = fi[31:0];
        end
      end
    endcase
  end

  // mul rounding, then first divide step
  always_comb begin
    logic [63:0] pm;
    logic [63:0] m;
    pst_t        x;
    pm = s1_r.prod[63] ? 64'(-s1_r.prod) : 64'(s1_r.prod);
    m  = (pm + HALF) >> FRACTION_BITS;
    x       = '0;
    x.cls   = s1_r.cls;
    x.res   = s1_r.res;
    x.n     = s1_r.n;
    x.d     = s1_r.d;
    x.neg   = s1_r.neg;
    if (s1_r.cls == CLS_MUL) begin
      x.res = '0;
      if (!s1_r.prod[63] && m > 64'h7FFFFFFF) begin
        x.res.result_value = FX_MAX;
        x.res.status       = ST_OVF;
      end else if (s1_r.prod[63] && m > 64'h80000000) begin
        x.res.result_value = FX_MIN;
        x.res.status       = ST_OVF;
      end else begin
        x.res.result_value = s1_r.prod[63] ? -m[31:0] : m[31:0];
      end
    end
    p_in = x;
  end

  assign p_nxt[0] = div_step(p_in);

  for (genvar k = 1; k < NW; k++) begin : g_div
    assign p_nxt[k] = div_step(p_r[k-1]);
  end

  always_comb begin
    logic over;
    pst_t l;
    over    = 1'b0;
    l       = p_r[NW-1];
    out_nxt = l.res;
    if (l.cls == CLS_DIV) begin
      over = l.big || (l.neg ? (l.q > 33'h080000000) : (l.q > 33'h07FFFFFFF));
      out_nxt = '0;
      if (over) begin
        out_nxt.result_value = l.neg ? FX_MIN : FX_MAX;
        out_nxt.status       = ST_OVF;
      end else begin
        out_nxt.result_value = l.neg ? -l.q[31:0] : l.q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NW; i++) begin
        p_valid_r[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_r   <= !q_empty;
      p_valid_r[0] <= s1_valid_r;
      for (int i = 1; i < NW; i++) begin
        p_valid_r[i] <= p_valid_r[i-1];
      end
      out_valid_r <= p_valid_r[NW-1];
    end
    if (adv) begin
      s1_r  <= s1_nxt;
      out_r <= out_nxt;
      for (int i = 0; i < NW; i++) begin
        p_r[i] <= p_nxt[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/fixed_point_alu_q24_8.sv
// Signed 32-bit fixed point ALU (default Q24.8). One transfer in gives one
// transfer out, in order. Accepts one item per cycle while in_stall is low.
// Between input and output lie the input register, the queue, the operand
// stage, the divider, which resolves one quotient bit per pipeline stage
// over 34 + FRACTION_BITS stages, and the output register. A four-entry
// queue sits between the input/classify stage and the execution pipeline;
// the whole execution pipeline holds while a finished result waits under
// out_stall.
module fixed_point_alu_q24_8
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  fpa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output fpa_out_t out_data
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  fpa_entry_t q_wdata;
  fpa_entry_t q_head;

  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  fpa_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full)
    else $error("input stalled without a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.compare_true) |->
      (out_data.result_value == '0 && out_data.status == ST_OK))
    else $error("compare result carries value or status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_OVF ||
                   out_data.status == ST_DIV0))
    else $error("bad status code");

endmodule

// File: test/fixed_point_alu_q24_8_test.sv
`timescale 1ns / 100ps

module fixed_point_alu_q24_8_test;
  import fpa_pkg::*;

  localparam int FB = 8;
  localparam int LATENCY = FB + 37;
  localparam int STALL_LIMIT = 4000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  fpa_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  fpa_out_t out_data;

  fixed_point_alu_q24_8 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  typedef struct {
    fpa_in_t  op;
    logic     known;
    fpa_out_t res;
  } vector_t;

  fpa_out_t alu_results[$];
  int       errors = 0;
  int       idle_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     done = 0;
  vector_t  vectors[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(logic signed [63:0] v, ref logic [1:0] st);
    if (v > 64'sd2147483647) begin
      st = ST_OVF;
      return FX_MAX;
    end
    if (v < -64'sd2147483648) begin
      st = ST_OVF;
      return FX_MIN;
    end
    return v[31:0];
  endfunction

  function automatic fpa_out_t alu_predict(fpa_in_t op);
    fpa_out_t r;
    logic signed [63:0] a, b, p, s;
    logic [63:0] m, n, d, q;
    logic [1:0] st;
    a = 64'(op.operand_a);
    b = 64'(op.operand_b);
    r = '0;
    st = ST_OK;
    case (op.mode)
      MODE_ADD: r.result_value = sat32(a + b, st);
      MODE_SUB: r.result_value = sat32(a - b, st);
      MODE_MUL: begin
        p = a * b;
        m = p < 0 ? -p : p;
        m = (m + (64'd1 << (FB - 1))) >> FB;
        s = p < 0 ? -$signed(m) : $signed(m);
        r.result_value = sat32(s, st);
      end
      MODE_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
          r.result_value = a > 0 ? FX_MAX : (a < 0 ? FX_MIN : 32'sd0);
        end else begin
          n = (a < 0 ? -a : a) << FB;
          d = b < 0 ? -b : b;
          q = (2 * n + d) / (2 * d);
          s = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
          r.result_value = sat32(s, st);
        end
      end
      MODE_GT: r.compare_true = a > b;
      MODE_LT: r.compare_true = a < b;
      MODE_GE: r.compare_true = a >= b;
      MODE_LE: r.compare_true = a <= b;
      MODE_EQ: r.compare_true = a == b;
      MODE_NE: r.compare_true = a != b;
      MODE_MIN: r.result_value = (a > b) ? b[31:0] : a[31:0];
      MODE_MAX: r.result_value = (a < b) ? b[31:0] : a[31:0];
      MODE_INC: r.result_value = sat32(a + 1, st);
      MODE_DEC: r.result_value = sat32(a - 1, st);
      MODE_TO_INT: r.result_value = op.operand_a >>> FB;
      default: r.result_value = sat32(a * (64'sd1 <<< FB), st);
    endcase
    r.status = st;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return FX_MAX - $urandom_range(0, 3);
      1: return FX_MIN + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 600)) - 300;
      3: return 0;
      4, 5: return $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
      6: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_vec(logic [3:0] m, logic signed [31:0] a, logic signed [31:0] b,
                         logic known = 0, logic signed [31:0] v = 0,
                         logic c = 0, logic [1:0] st = ST_OK);
    vector_t t;
    t.op = '{mode: m, operand_a: a, operand_b: b};
    t.known = known;
    t.res = '{result_value: v, compare_true: c, status: st};
    vectors.push_back(t);
  endtask

  task automatic send(fpa_in_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= op;
    alu_results.push_back(alu_predict(op));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_known(fpa_in_t op, fpa_out_t res);
    if (alu_predict(op) !== res) begin
      $display("%0t table row mode %0d: expected %h actual %h",
               $time, op.mode, res, alu_predict(op));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    fpa_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (alu_results.size() == 0) begin
        $display("%0t unexpected transfer %h", $time, out_data);
        errors++;
      end else begin
        e = alu_results.pop_front();
        if (out_data.result_value !== e.result_value)
          $display("%0t result_value expected %h actual %h", $time,
                   e.result_value, out_data.result_value);
        if (out_data.compare_true !== e.compare_true)
          $display("%0t compare_true expected %b actual %b", $time,
                   e.compare_true, out_data.compare_true);
        if (out_data.status !== e.status)
          $display("%0t status expected %0d actual %0d", $time, e.status, out_data.status);
        if (out_data !== e) errors++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || done || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    fpa_in_t op;
    int phase;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    add_vec(MODE_ADD, FX_MAX, 1, 1, FX_MAX, 0, ST_OVF);
    add_vec(MODE_ADD, FX_MIN, -1, 1, FX_MIN, 0, ST_OVF);
    add_vec(MODE_SUB, FX_MIN, 1, 1, FX_MIN, 0, ST_OVF);
    add_vec(MODE_SUB, 32'sd5, 32'sd3, 1, 32'sd2);
    add_vec(MODE_MUL, 32'sd256, 32'sd256, 1, 32'sd256);
    add_vec(MODE_MUL, FX_MAX, FX_MAX, 1, FX_MAX, 0, ST_OVF);
    add_vec(MODE_MUL, FX_MIN, FX_MIN);
    add_vec(MODE_MUL, -32'sd1, 32'sd128);
    add_vec(MODE_DIV, 32'sd100, 0, 1, FX_MAX, 0, ST_DIV0);
    add_vec(MODE_DIV, -32'sd100, 0, 1, FX_MIN, 0, ST_DIV0);
    add_vec(MODE_DIV, 0, 0, 1, 0, 0, ST_DIV0);
    add_vec(MODE_DIV, FX_MIN, -32'sd1);
    add_vec(MODE_DIV, -32'sd1, 32'sd512);
    add_vec(MODE_GT, FX_MAX, FX_MIN, 1, 0, 1);
    add_vec(MODE_LT, FX_MAX, FX_MIN, 1, 0, 0);
    add_vec(MODE_GE, 32'sd7, 32'sd7, 1, 0, 1);
    add_vec(MODE_LE, FX_MIN, FX_MIN, 1, 0, 1);
    add_vec(MODE_EQ, -32'sd1, 32'sd1, 1, 0, 0);
    add_vec(MODE_NE, -32'sd1, 32'sd1, 1, 0, 1);
    add_vec(MODE_MIN, 32'sd9, 32'sd9);
    add_vec(MODE_MAX, FX_MIN, FX_MAX, 1, FX_MAX);
    add_vec(MODE_INC, FX_MAX, 0, 1, FX_MAX, 0, ST_OVF);
    add_vec(MODE_DEC, FX_MIN, 0, 1, FX_MIN, 0, ST_OVF);
    add_vec(MODE_TO_INT, -32'sd1, 0, 1, -32'sd1);
    add_vec(MODE_FROM_INT, 32'sh00800000, 0, 1, FX_MAX, 0, ST_OVF);

    foreach (vectors[i]) begin
      if (vectors[i].known) check_known(vectors[i].op, vectors[i].res);
      send(vectors[i].op);
    end

    for (int i = 0; i < 1200; i++) begin
      phase = i / 240;
      send_idle_pct = (phase == 1 || phase == 4) ? 48 : (phase == 3 ? 11 : 0);
      recv_stall_pct = (phase == 2 || phase == 4) ? 48 : (phase == 3 ? 11 : 0);
      if (i == 600) begin
        in_valid <= 0;
        while (alu_results.size() != 0) @(negedge clk);
      end
      op.mode = 4'($urandom_range(0, 15));
      op.operand_a = rand_operand();
      op.operand_b = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_operand();
      if ($urandom_range(0, 7) == 0) op.operand_b = op.operand_a;
      send(op);
    end
    in_valid <= 0;
    recv_stall_pct = 0;
    while (alu_results.size() != 0) @(negedge clk);
    done = 1;
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
